FILE: design/sjf_pkg.sv
// ----------------------------------------------------------------------------
// SJF scheduler package
// Shared types and field widths of the shortest-job-first scheduler.
// ----------------------------------------------------------------------------
package sjf_pkg;

  localparam int unsigned ID_W         = 16;
  localparam int unsigned BURST_W      = 16;
  localparam int unsigned ARR_W        = 16;
  localparam int unsigned TIME_W       = 24;
  localparam int unsigned SUM_W        = 30;
  localparam int unsigned PROC_COUNT_W = 7;

  localparam int unsigned REC_W        = ID_W + BURST_W + ARR_W;
  localparam int unsigned IN_TDATA_W   = 48;
  localparam int unsigned OUT_TDATA_W  = 136;
  localparam int unsigned OUT_FIELDS_W =
    ID_W + TIME_W + TIME_W + SUM_W + SUM_W + PROC_COUNT_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_EMIT
  } sjf_state_e;

  typedef struct packed {
    logic load_rec;
    logic scan_init;
    logic jump_time;
    logic serve;
    logic emit;
  } sjf_ctrl_t;

endpackage

FILE: design/sjf_nonpreemptive_scheduler.sv
// ----------------------------------------------------------------------------
// Non-preemptive shortest-job-first scheduler
// Loads process records, then emits the service order with waiting and
// turnaround times and running totals.
// ----------------------------------------------------------------------------
// Records load at one per cycle into a table of MAX_PROCS entries; records
// beyond capacity are dropped and flagged on every result of the batch. The
// record with tlast starts scheduling from tick zero. Each result costs one
// sequential scan of the table through its single read port, plus a second
// scan whenever no process has arrived yet and time jumps to the earliest
// pending arrival. The input is not ready while a batch is being scheduled;
// the block accepts a new batch once the final result is in the output
// register.
module sjf_nonpreemptive_scheduler
  import sjf_pkg::*;
#(
  parameter int unsigned MAX_PROCS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // proc_id[15:0], burst_time[31:16], arrival_time[47:32]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // last_item
  input  logic                   s_axis_tlast_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // served_id[15:0], wait_time[39:16], turnaround_time[63:40],
  // total_wait[93:64], total_turnaround[123:94], proc_count[130:124],
  // overflow_flag[131], zero[135:132]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // last_result
  output logic                   m_axis_tlast_o
);

  localparam int unsigned IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);

  sjf_state_e state_q, state_d;
  sjf_ctrl_t  ctrl;

  logic [CNT_W-1:0]     count_q;
  logic [CNT_W-1:0]     scan_q;
  logic [CNT_W-1:0]     pos_q;
  logic                 rd_v_q;
  logic [IDX_W-1:0]     rd_idx_q;
  logic [MAX_PROCS-1:0] served_q;
  logic                 dropped_q;
  logic [TIME_W-1:0]    time_q;
  logic [SUM_W-1:0]     wait_sum_q;
  logic [SUM_W-1:0]     turn_sum_q;
  logic [TIME_W-1:0]    wait_q;

  logic                 found_q;
  logic [IDX_W-1:0]     best_idx_q;
  logic [ID_W-1:0]      best_id_q;
  logic [BURST_W-1:0]   best_burst_q;
  logic [ARR_W-1:0]     best_arr_q;
  logic [ARR_W-1:0]     min_arr_q;

  logic                 m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;
  logic                 m_last_q;

  logic                 in_fire;
  logic                 out_free;
  logic                 scan_done;
  logic                 last_pos;
  logic [REC_W-1:0]     rd_data;
  logic [ID_W-1:0]      rd_id;
  logic [BURST_W-1:0]   rd_burst;
  logic [ARR_W-1:0]     rd_arr;
  logic                 rd_open;
  logic                 rd_arrived;
  logic [TIME_W-1:0]    turn;
  logic [SUM_W-1:0]     wait_sum_d;
  logic [SUM_W-1:0]     turn_sum_d;

  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !m_valid_q || m_axis_tready_i;
  assign scan_done = (scan_q == count_q) && !rd_v_q;
  assign last_pos  = (pos_q == count_q - CNT_W'(1));

  sjf_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_PROCS)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (ctrl.load_rec),
    .wr_addr_i (count_q[IDX_W-1:0]),
    .wr_data_i (s_axis_tdata_i[REC_W-1:0]),
    .rd_addr_i (scan_q[IDX_W-1:0]),
    .rd_data_o (rd_data)
  );

  assign rd_id      = rd_data[ID_W-1:0];
  assign rd_burst   = rd_data[ID_W +: BURST_W];
  assign rd_arr     = rd_data[ID_W+BURST_W +: ARR_W];
  assign rd_open    = rd_v_q && !served_q[rd_idx_q];
  assign rd_arrived = {{(TIME_W-ARR_W){1'b0}}, rd_arr} <= time_q;

  assign turn       = time_q - {{(TIME_W-ARR_W){1'b0}}, best_arr_q};
  assign wait_sum_d = wait_sum_q + {{(SUM_W-TIME_W){1'b0}}, wait_q};
  assign turn_sum_d = turn_sum_q + {{(SUM_W-TIME_W){1'b0}}, turn};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire && s_axis_tlast_i) state_d = ST_SCAN;
      ST_SCAN: if (scan_done) state_d = ST_PICK;
      ST_PICK: state_d = found_q ? ST_EMIT : ST_SCAN;
      ST_EMIT: begin
        if (out_free) state_d = last_pos ? ST_IDLE : ST_SCAN;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        ctrl.load_rec   = in_fire && (count_q < CNT_W'(MAX_PROCS));
        ctrl.scan_init  = in_fire && s_axis_tlast_i;
      end
      ST_SCAN: ;
      ST_PICK: begin
        ctrl.serve     = found_q;
        ctrl.jump_time = !found_q;
        ctrl.scan_init = !found_q;
      end
      ST_EMIT: begin
        ctrl.emit      = out_free;
        ctrl.scan_init = out_free && !last_pos;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      scan_q     <= '0;
      pos_q      <= '0;
      rd_v_q     <= 1'b0;
      served_q   <= '0;
      dropped_q  <= 1'b0;
      time_q     <= '0;
      wait_sum_q <= '0;
      turn_sum_q <= '0;
      found_q    <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= (state_q == ST_SCAN) && (scan_q < count_q);

      if (ctrl.load_rec) begin
        count_q                     <= count_q + CNT_W'(1);
        served_q[count_q[IDX_W-1:0]] <= 1'b0;
      end else if (in_fire) begin
        dropped_q <= 1'b1;
      end

      if (ctrl.scan_init) begin
        scan_q  <= '0;
        found_q <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        if (scan_q < count_q) scan_q <= scan_q + CNT_W'(1);
        if (rd_open && rd_arrived && (!found_q || rd_burst < best_burst_q)) begin
          found_q <= 1'b1;
        end
      end

      if (ctrl.jump_time) time_q <= {{(TIME_W-ARR_W){1'b0}}, min_arr_q};

      if (ctrl.serve) begin
        time_q               <= time_q + {{(TIME_W-BURST_W){1'b0}}, best_burst_q};
        served_q[best_idx_q] <= 1'b1;
      end

      if (ctrl.emit) begin
        if (last_pos) begin
          count_q    <= '0;
          pos_q      <= '0;
          served_q   <= '0;
          dropped_q  <= 1'b0;
          time_q     <= '0;
          wait_sum_q <= '0;
          turn_sum_q <= '0;
        end else begin
          pos_q      <= pos_q + CNT_W'(1);
          wait_sum_q <= wait_sum_d;
          turn_sum_q <= turn_sum_d;
        end
      end

      if (ctrl.emit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= scan_q[IDX_W-1:0];

    if (ctrl.scan_init) begin
      min_arr_q <= '1;
    end else if (state_q == ST_SCAN) begin
      if (rd_open && rd_arrived && (!found_q || rd_burst < best_burst_q)) begin
        best_idx_q   <= rd_idx_q;
        best_id_q    <= rd_id;
        best_burst_q <= rd_burst;
        best_arr_q   <= rd_arr;
      end
      if (rd_open && rd_arr < min_arr_q) min_arr_q <= rd_arr;
    end

    if (ctrl.serve) wait_q <= time_q - {{(TIME_W-ARR_W){1'b0}}, best_arr_q};

    if (ctrl.emit) begin
      m_data_q <= {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}},
                   dropped_q,
                   PROC_COUNT_W'(count_q),
                   turn_sum_d,
                   wait_sum_d,
                   turn,
                   wait_q,
                   best_id_q};
      m_last_q <= last_pos;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_PROCS))
    else $error("table count beyond capacity");

  a_time_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && $past(state_q) != ST_IDLE) |-> time_q >= $past(time_q))
    else $error("schedule time went backwards");

  a_pick_unserved : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PICK && found_q) |-> !served_q[best_idx_q])
    else $error("picked a process already served");

  a_batch_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.emit && last_pos) |=>
      (state_q == ST_IDLE && count_q == '0 && served_q == '0 && !dropped_q))
    else $error("batch state not cleared after final result");

endmodule

FILE: design/sjf_ram.sv
// ----------------------------------------------------------------------------
// SJF generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module sjf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   wr_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                       wr_data_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                       rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule
